[src/text_console_char_writer_top_defines.svh]
// Assertion macros used by the console controller.
// Both expect clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH

// Same-cycle implication.
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tccw_pkg.sv]
package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W         = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CELL_W       = 16;
    localparam int CURSOR_W     = 11;
    localparam int ATTR_W       = 8;
    localparam int TAB_W        = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [TAB_W-1:0]  TAB_RESET    = 7'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH      = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } tccw_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_NORM,
        ST_MOD,
        ST_PUT,
        ST_RDATA,
        ST_DONE
    } tccw_state_t;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [CHAR_W-1:0]       char_code;
        logic [CELL_INDEX_W-1:0] cell_index;
    } tccw_req_t;

    typedef struct packed {
        logic                    valid;
        logic [CELL_W-1:0]       cell_data;
        logic [CURSOR_W-1:0]     cursor_location;
    } tccw_rslt_t;

endpackage

[src/tccw_if.sv]
interface tccw_req_if;
    logic                               valid;
    logic                               ready;
    logic [tccw_pkg::OP_W-1:0]          operation;
    logic [tccw_pkg::CHAR_W-1:0]        char_code;
    logic [tccw_pkg::CELL_INDEX_W-1:0]  cell_index;

    modport source (output valid, output operation, output char_code,
                    output cell_index, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_index, output ready);
endinterface

interface tccw_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [tccw_pkg::CELL_W-1:0]        cell_data;
    logic [tccw_pkg::CURSOR_W-1:0]      cursor_location;

    modport source (output valid, output cell_data, output cursor_location,
                    input ready);
    modport sink   (input valid, input cell_data, input cursor_location,
                    output ready);
endinterface

[src/tccw_mem.sv]
module tccw_mem #(
    parameter int DEPTH = tccw_pkg::COLUMNS_DEF * tccw_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [tccw_pkg::CELL_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [tccw_pkg::CELL_W-1:0] rd_data
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] cell_mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    // read-before-write, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cell_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/tccw_ctrl.sv]
`include "text_console_char_writer_top_defines.svh"

module tccw_ctrl #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF,
    parameter int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tccw_pkg::tccw_req_t         req,
    input  logic [tccw_pkg::ATTR_W-1:0] text_attribute,
    input  logic [tccw_pkg::TAB_W-1:0]  tab_width,
    output tccw_pkg::tccw_rslt_t        rslt,
    input  logic                        rslt_ready,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [tccw_pkg::CELL_W-1:0] wr_data,
    output logic [AW-1:0]               rd_addr,
    input  logic [tccw_pkg::CELL_W-1:0] rd_data
);
    import tccw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LW     = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PH_W   = (COL_W > TAB_W) ? COL_W : TAB_W;
    localparam int IDX_CW = (AW > CELL_INDEX_W) ? AW : CELL_INDEX_W;

    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_END   = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [AW-1:0]    CNT_LAST  = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]    COPY_END  = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0]    ROW_STEP  = AW'(COLUMNS);

    tccw_state_t       state_reg, state_next;
    tccw_state_t       ret_reg, ret_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              tab_reg, tab_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              copy_reg, copy_next;
    logic [CELL_W-1:0] blank_reg, blank_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]     pipe_addr_reg, pipe_addr_next;
    logic              pipe_copy_reg, pipe_copy_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              rd_ok_reg, rd_ok_next;

    logic [LW-1:0]     cur_lin;
    logic [PH_W-1:0]   tw_eff;
    logic [PH_W-1:0]   phase_inc;
    logic [CELL_W-1:0] attr_blank;

    assign cur_lin    = LW'(row_reg) * LW'(COLUMNS) + LW'(col_reg);
    assign tw_eff     = (tab_width == '0) ? PH_W'(1) : PH_W'(tab_width);
    assign phase_inc  = ((phase_reg + PH_W'(1)) == tw_eff) ? '0 : phase_reg + PH_W'(1);
    assign attr_blank = {text_attribute, CHAR_SPACE};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            ret_reg        <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            ch_reg         <= '0;
            tab_reg        <= 1'b0;
            phase_reg      <= '0;
            cnt_reg        <= '0;
            copy_reg       <= 1'b0;
            blank_reg      <= RESET_CELL;
            pipe_valid_reg <= 1'b0;
            pipe_addr_reg  <= '0;
            pipe_copy_reg  <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            ch_reg         <= ch_next;
            tab_reg        <= tab_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            copy_reg       <= copy_next;
            blank_reg      <= blank_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_addr_reg  <= pipe_addr_next;
            pipe_copy_reg  <= pipe_copy_next;
            rd_ok_reg      <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        ch_next         = ch_reg;
        tab_next        = tab_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        copy_next       = copy_reg;
        blank_next      = blank_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        pipe_copy_next  = pipe_copy_reg;
        data_next       = data_reg;
        rd_ok_next      = rd_ok_reg;

        in_ready = 1'b0;
        rslt.valid           = 1'b0;
        rslt.cell_data       = data_reg;
        rslt.cursor_location = CURSOR_W'(cur_lin);

        // sweep write stage owns the port unless a put writes
        wr_en   = pipe_valid_reg;
        wr_addr = pipe_addr_reg;
        wr_data = pipe_copy_reg ? rd_data : blank_reg;
        rd_addr = cnt_reg + ROW_STEP;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = AW'(req.cell_index);
                if (in_valid)
                begin
                    data_next  = '0;
                    rd_ok_next = 1'b0;
                    case (req.operation)
                        OP_PUT:
                        begin
                            ch_next  = req.char_code;
                            tab_next = 1'b0;
                            if (req.char_code == CHAR_NEWLINE)
                            begin
                                col_next = '0;
                                if (row_reg == ROW_LAST)
                                begin
                                    cnt_next   = '0;
                                    copy_next  = 1'b1;
                                    blank_next = attr_blank;
                                    ret_next   = ST_DONE;
                                    state_next = ST_SWEEP;
                                end
                                else
                                begin
                                    row_next   = row_reg + ROW_W'(1);
                                    state_next = ST_DONE;
                                end
                            end
                            else if (req.char_code == CHAR_TAB)
                            begin
                                tab_next   = 1'b1;
                                ch_next    = CHAR_SPACE;
                                ret_next   = ST_MOD;
                                state_next = ST_NORM;
                            end
                            else
                            begin
                                ret_next   = ST_PUT;
                                state_next = ST_NORM;
                            end
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            copy_next  = 1'b0;
                            blank_next = attr_blank;
                            ret_next   = ST_DONE;
                            state_next = ST_SWEEP;
                        end
                        OP_READ:
                        begin
                            rd_ok_next = IDX_CW'(req.cell_index) < IDX_CW'(CELL_COUNT);
                            state_next = ST_RDATA;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SWEEP:
            begin
                pipe_valid_next = 1'b1;
                pipe_addr_next  = cnt_reg;
                pipe_copy_next  = copy_reg && (cnt_reg < COPY_END);
                cnt_next        = cnt_reg + AW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ret_reg;
            end

            ST_NORM:
            begin
                if (col_reg >= COL_END)
                begin
                    col_next = '0;
                    if (row_reg == ROW_LAST)
                    begin
                        cnt_next   = '0;
                        copy_next  = 1'b1;
                        blank_next = attr_blank;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ret_reg;
                    end
                end
                else
                begin
                    state_next = ret_reg;
                end
                phase_next = PH_W'(col_next);
            end

            ST_MOD:
            begin
                // column mod tab width by repeated subtraction
                if (phase_reg >= tw_eff)
                begin
                    phase_next = phase_reg - tw_eff;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT:
            begin
                wr_en    = 1'b1;
                wr_addr  = AW'(cur_lin);
                wr_data  = {text_attribute, ch_reg};
                col_next = col_reg + COL_W'(1);
                if (!tab_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    phase_next = phase_inc;
                    if ((col_reg < COL_LAST) && (phase_inc != '0))
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        ret_next   = ST_DONE;
                        state_next = ST_NORM;
                    end
                end
            end

            ST_RDATA:
            begin
                data_next  = rd_ok_reg ? rd_data : '0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                rslt.valid = 1'b1;
                if (rslt_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TCCW_ASSERT_NOW(a_cursor_range, 1'b1, (row_reg <= ROW_LAST) && (col_reg <= COL_END), "cursor out of range")
    `TCCW_ASSERT_NOW(a_rslt_no_write, rslt.valid, !wr_en, "memory write while result pending")
    `TCCW_ASSERT_NOW(a_pipe_in_sweep, pipe_valid_reg, (state_reg == ST_SWEEP) || (state_reg == ST_DRAIN), "sweep write outside sweep")
    `TCCW_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_reg != ST_IDLE, "accepted request left block idle")
    `TCCW_ASSERT_NEXT(a_put_single, (state_reg == ST_PUT) && !tab_reg, state_reg == ST_DONE, "plain put did not finish")

endmodule

[src/text_console_char_writer_top.sv]
// Text console character writer.
// Channels: req (sink) carries operation, char_code and cell_index; rsp
// (source) returns cell_data and cursor_location, one result per request.
// Both use valid/ready; a transfer happens when both are high on a clk edge.
// Config: cfg_we writes cfg_data to register cfg_index (0 text attribute,
// 1 tab width); the user must do so only while the block is idle, which the
// block itself does not enforce.
// A tab writes spaces up to the next tab stop once the column's remainder by
// the tab width is found by repeated subtraction. Clear and scroll sweep the
// screen memory one cell per cycle, and a tab may scroll twice.
// One request is in work at a time; the next is taken once the result has
// moved into the output register, which may still wait on rsp.ready.
// Reset: cursor goes home and a clearing pass writes every cell to 0x0720,
// during which req.ready stays low.
// A stalled receiver holds the result in the output register; the block
// finishes the next request and then waits with it.
module text_console_char_writer_top #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tccw_req_if.sink                        req,
    tccw_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tccw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);

    // configuration registers
    logic [ATTR_W-1:0] attr_reg;
    logic [TAB_W-1:0]  tab_width_reg;

    // output register, decouples the sequencer from rsp backpressure
    logic                out_valid_reg;
    logic [CELL_W-1:0]   out_data_reg;
    logic [CURSOR_W-1:0] out_cursor_reg;

    tccw_req_t  req_bus;
    tccw_rslt_t rslt;
    logic       rslt_ready;

    // memory port wires
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;

    assign req_bus.operation  = req.operation;
    assign req_bus.char_code  = req.char_code;
    assign req_bus.cell_index = req.cell_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            tab_width_reg <= TAB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEXT_ATTRIBUTE: attr_reg      <= ATTR_W'(cfg_data);
                CFG_TAB_WIDTH:      tab_width_reg <= TAB_W'(cfg_data);
                default:            ;
            endcase
        end
    end

    // result may load when the slot is empty or being drained this cycle
    assign rslt_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rslt.valid && rslt_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rslt.valid && rslt_ready)
        begin
            out_data_reg   <= rslt.cell_data;
            out_cursor_reg <= rslt.cursor_location;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.cell_data       = out_data_reg;
    assign rsp.cursor_location = out_cursor_reg;

    // sequencer: cursor, put/tab/newline flow, clear and scroll sweeps
    tccw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_ready       (req.ready),
        .req            (req_bus),
        .text_attribute (attr_reg),
        .tab_width      (tab_width_reg),
        .rslt           (rslt),
        .rslt_ready     (rslt_ready),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    // screen store, one write and one registered read per cycle
    tccw_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
